FILE: rtl/idos_pkg.sv
// Shared definitions for the inductor difference-over-sum position block.
// Holds register reset values, field widths, register index codes and the
// divider control/status types. No dependencies.
package idos_pkg;

  localparam int unsigned SampleBitsDef = 12;
  localparam int unsigned GainW         = 10;
  localparam int unsigned LimitW        = 15;
  localparam int unsigned OutW          = LimitW + 1;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 16;

  localparam int unsigned FloorRst     = 5;
  localparam int unsigned CeilingRst   = 4050;
  localparam int unsigned ThresholdRst = 300;
  localparam int unsigned GainRst      = 400;
  localparam int unsigned LimitRst     = 500;
  localparam int          KeptRst      = 500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLOOR     = 3'd0,
    CFG_CEILING   = 3'd1,
    CFG_THRESHOLD = 3'd2,
    CFG_GAIN      = 3'd3,
    CFG_LIMIT     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/idos_cfg_regs.sv
// Configuration register file: clamp bounds, weak threshold, gain and limit.
// Depends on idos_pkg for widths, reset values and register index codes.
module idos_cfg_regs #(
  parameter int unsigned SAMPLE_BITS = idos_pkg::SampleBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [idos_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [idos_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic [SAMPLE_BITS-1:0]          floor_o,
  output logic [SAMPLE_BITS-1:0]          ceiling_o,
  output logic [SAMPLE_BITS-1:0]          threshold_o,
  output logic [idos_pkg::GainW-1:0]      gain_o,
  output logic [idos_pkg::LimitW-1:0]     limit_o
);

  logic [SAMPLE_BITS-1:0]      floor_q, ceiling_q, threshold_q;
  logic [idos_pkg::GainW-1:0]  gain_q;
  logic [idos_pkg::LimitW-1:0] limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q     <= SAMPLE_BITS'(idos_pkg::FloorRst);
      ceiling_q   <= SAMPLE_BITS'(idos_pkg::CeilingRst);
      threshold_q <= SAMPLE_BITS'(idos_pkg::ThresholdRst);
      gain_q      <= idos_pkg::GainW'(idos_pkg::GainRst);
      limit_q     <= idos_pkg::LimitW'(idos_pkg::LimitRst);
    end else if (cfg_valid_i) begin
      unique case (idos_pkg::cfg_idx_e'(cfg_index_i))
        idos_pkg::CFG_FLOOR:     floor_q     <= cfg_data_i[SAMPLE_BITS-1:0];
        idos_pkg::CFG_CEILING:   ceiling_q   <= cfg_data_i[SAMPLE_BITS-1:0];
        idos_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i[SAMPLE_BITS-1:0];
        idos_pkg::CFG_GAIN:      gain_q      <= cfg_data_i[idos_pkg::GainW-1:0];
        idos_pkg::CFG_LIMIT:     limit_q     <= cfg_data_i[idos_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign floor_o     = floor_q;
  assign ceiling_o   = ceiling_q;
  assign threshold_o = threshold_q;
  assign gain_o      = gain_q;
  assign limit_o     = limit_q;

endmodule

FILE: rtl/idos_divider.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
// Depends on idos_pkg for the control and status struct types.
module idos_divider #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  idos_pkg::div_ctrl_t ctrl_i,
  output idos_pkg::div_stat_t stat_o,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output logic [NUM_W-1:0]    quotient_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial, trial_sub;
  logic             fits;

  // The dividend shifts out of the top of quo_q while quotient bits enter below.
  always_comb begin
    trial     = {rem_q, quo_q[NUM_W-1]};
    trial_sub = trial - {1'b0, den_q};
    fits      = trial >= {1'b0, den_q};
    rem_d     = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_d     = {quo_q[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_ends_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

endmodule

FILE: rtl/inductor_diff_over_sum_position.sv
// Position sensing from a left/right inductor pair: each request is clamped, the
// kept difference is updated, and gain * difference / (left + right + 1) is
// returned saturated to +/- the configured limit. A request passes through the
// clamp, keep, multiply, launch, divide and saturate states in order, and the
// next request is taken only once the block is back in idle. The divider
// produces one quotient bit per cycle over the GAIN + SAMPLE_BITS bit product.
// A new request is taken once the previous one reaches the output register, so
// the result may wait there while the next request is computed; a result still
// waiting when the next one is done holds it.
// Depends on idos_pkg, idos_cfg_regs and idos_divider.
module inductor_diff_over_sum_position #(
  parameter int unsigned SAMPLE_BITS = idos_pkg::SampleBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [idos_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [idos_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [SAMPLE_BITS-1:0]           left_sample_i,
  input  logic [SAMPLE_BITS-1:0]           right_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [idos_pkg::OutW-1:0] position_error_o
);

  localparam int unsigned DiffW = SAMPLE_BITS + 1;
  localparam int unsigned DenW  = SAMPLE_BITS + 1;
  localparam int unsigned NumW  = idos_pkg::GainW + SAMPLE_BITS;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLAMP  = 7'b0000010,
    ST_KEEP   = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_LAUNCH = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_SAT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0]      floor_v, ceiling_v, threshold_v;
  logic [idos_pkg::GainW-1:0]  gain_v;
  logic [idos_pkg::LimitW-1:0] limit_v;

  idos_cfg_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .floor_o     (floor_v),
    .ceiling_o   (ceiling_v),
    .threshold_o (threshold_v),
    .gain_o      (gain_v),
    .limit_o     (limit_v)
  );

  logic [SAMPLE_BITS-1:0] left_raw_q, right_raw_q, left_q, right_q;
  logic signed [DiffW-1:0] kept_q, kept_d;
  logic [DenW-1:0]         den_q;
  logic [NumW-1:0]         num_q;
  logic                    neg_q;
  logic                    out_valid_q;
  logic signed [idos_pkg::OutW-1:0] out_q;

  idos_pkg::div_ctrl_t div_ctrl;
  idos_pkg::div_stat_t div_stat;
  logic [NumW-1:0]     quotient;

  idos_divider #(.NUM_W(NumW), .DEN_W(DenW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .stat_o     (div_stat),
    .num_i      (num_q),
    .den_i      (den_q),
    .quotient_o (quotient)
  );

  function automatic logic [SAMPLE_BITS-1:0] clamp_sample(
    input logic [SAMPLE_BITS-1:0] x,
    input logic [SAMPLE_BITS-1:0] lo,
    input logic [SAMPLE_BITS-1:0] hi
  );
    logic [SAMPLE_BITS-1:0] r;
    // The floor test comes first, so it wins at the low end when the floor lies above the ceiling.
    priority if (x <= lo) r = lo;
    else if (x >= hi)     r = hi;
    else                  r = x;
    return r;
  endfunction

  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        abs_diff, abs_kept;
  logic [SAMPLE_BITS-1:0]  smaller;
  logic                    is_weak, bigger, same_sign;
  logic                    can_load;
  logic [idos_pkg::LimitW-1:0] sat_mag;

  always_comb begin
    diff      = $signed({1'b0, left_q}) - $signed({1'b0, right_q});
    abs_diff  = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
    abs_kept  = kept_q[DiffW-1] ? DiffW'(-kept_q) : DiffW'(kept_q);
    smaller   = (left_q < right_q) ? left_q : right_q;
    is_weak   = smaller < threshold_v;
    bigger    = abs_diff > abs_kept;
    same_sign = ((diff > 0) && (kept_q > 0)) || ((diff < 0) && (kept_q < 0));
    kept_d    = (!is_weak || (bigger && same_sign)) ? diff : kept_q;
    sat_mag   = (quotient > NumW'(limit_v)) ? limit_v
                                            : quotient[idos_pkg::LimitW-1:0];
    can_load  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CLAMP;
      ST_CLAMP:  state_d = ST_KEEP;
      ST_KEEP:   state_d = ST_MUL;
      ST_MUL:    state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_DIV;
      ST_DIV:    if (div_stat.done) state_d = ST_SAT;
      ST_SAT:    if (can_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign div_ctrl.start = (state_q == ST_LAUNCH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kept_q      <= DiffW'(idos_pkg::KeptRst);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_KEEP) kept_q <= kept_d;
      if (state_q == ST_SAT && can_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      left_raw_q  <= left_sample_i;
      right_raw_q <= right_sample_i;
    end
    if (state_q == ST_CLAMP) begin
      left_q  <= clamp_sample(left_raw_q, floor_v, ceiling_v);
      right_q <= clamp_sample(right_raw_q, floor_v, ceiling_v);
    end
    if (state_q == ST_KEEP) begin
      den_q <= DenW'({1'b0, left_q} + {1'b0, right_q} + DenW'(1));
    end
    if (state_q == ST_MUL) begin
      num_q <= gain_v * abs_kept[SAMPLE_BITS-1:0];
      neg_q <= kept_q[DiffW-1];
    end
    if (state_q == ST_SAT && can_load) begin
      out_q <= neg_q ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});
    end
  end

  assign out_valid_o      = out_valid_q;
  assign position_error_o = out_q;

  a_ready_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_stat.busy)
    else $error("request taken while the divider is busy");

  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  a_out_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (position_error_o <= $signed({1'b0, limit_v})) &&
                    (position_error_o >= -$signed({1'b0, limit_v})))
    else $error("position error exceeds the configured limit");

endmodule

FILE: sim/inductor_diff_over_sum_position_tb.sv
`timescale 1ns / 1ps
// Testbench for inductor_diff_over_sum_position: drives sample pair requests and register
// writes, predicts every position error and checks it against the output in order.
// Depends on idos_pkg and the RTL of the block.
module inductor_diff_over_sum_position_tb;
  import idos_pkg::*;

  localparam int unsigned SB = SampleBitsDef;
  localparam int unsigned SampleMax = (1 << SB) - 1;
  localparam int unsigned GainMax = (1 << GainW) - 1;
  localparam int unsigned LimitMax = (1 << LimitW) - 1;
  localparam int unsigned DrainCycles = 2 * (SB + 17) + 10;
  localparam int unsigned WatchdogLimit = 4000;

  typedef struct packed {
    logic [SB-1:0] left;
    logic [SB-1:0] right;
  } sample_pair_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [CfgDataW-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [SB-1:0]           left_sample_i = '0;
  logic [SB-1:0]           right_sample_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OutW-1:0]  position_error_o;

  inductor_diff_over_sum_position #(
    .SAMPLE_BITS(SB)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .left_sample_i   (left_sample_i),
    .right_sample_i  (right_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .position_error_o(position_error_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the registers and the kept difference.
  int unsigned reg_floor     = FloorRst;
  int unsigned reg_ceiling   = CeilingRst;
  int unsigned reg_threshold = ThresholdRst;
  int unsigned reg_gain      = GainRst;
  int unsigned reg_limit     = LimitRst;
  int          kept_diff     = KeptRst;

  sample_pair_t           pending_pairs[$];
  logic signed [OutW-1:0] expected_errors[$];
  int unsigned            mismatch_count = 0;
  int unsigned            in_gap_max = 5;
  int unsigned            out_gap_max = 5;
  int unsigned            in_gap = 0;
  int unsigned            out_stall = 0;
  int unsigned            quiet_cycles = 0;

  function automatic int unsigned clamp_sample(input logic [SB-1:0] raw);
    // The floor test comes first, so a floor above the ceiling still wins at the low end.
    if (raw <= reg_floor) return reg_floor;
    if (raw >= reg_ceiling) return reg_ceiling;
    return raw;
  endfunction

  function automatic logic signed [OutW-1:0] predict_position(input logic [SB-1:0] l_raw,
                                                             input logic [SB-1:0] r_raw);
    int unsigned            lc, rc, smaller;
    int                     diff, mag_new, mag_kept;
    longint unsigned        num, den, quot;
    logic signed [OutW-1:0] res;
    lc = clamp_sample(l_raw);
    rc = clamp_sample(r_raw);
    diff = int'(lc) - int'(rc);
    smaller = (lc < rc) ? lc : rc;
    mag_new = (diff < 0) ? -diff : diff;
    mag_kept = (kept_diff < 0) ? -kept_diff : kept_diff;
    if (smaller >= reg_threshold) begin
      kept_diff = diff;
    end else if (mag_new > mag_kept &&
                 ((diff > 0 && kept_diff > 0) || (diff < 0 && kept_diff < 0))) begin
      kept_diff = diff;
    end
    mag_kept = (kept_diff < 0) ? -kept_diff : kept_diff;
    num = reg_gain;
    num = num * mag_kept;
    den = lc;
    den = den + rc + 1;
    quot = num / den;
    // Saturate on the full quotient before narrowing.
    if (quot > reg_limit) quot = reg_limit;
    res = quot[OutW-1:0];
    if (kept_diff < 0) res = -res;
    return res;
  endfunction

  function automatic logic [CfgDataW-1:0] with_junk(input int unsigned value,
                                                   input int unsigned w);
    // Bits above the register width are random and must be ignored by the block.
    return CfgDataW'(($urandom << w) | value);
  endfunction

  function automatic void push_pair(input int unsigned lv, input int unsigned rv);
    sample_pair_t p;
    p.left = SB'(lv);
    p.right = SB'(rv);
    pending_pairs.push_back(p);
  endfunction

  function automatic int unsigned near_value(input int unsigned center);
    int v;
    v = int'(center) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > int'(SampleMax)) v = SampleMax;
    return v;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FLOOR:     reg_floor = data[SB-1:0];
      CFG_CEILING:   reg_ceiling = data[SB-1:0];
      CFG_THRESHOLD: reg_threshold = data[SB-1:0];
      CFG_GAIN:      reg_gain = data[GainW-1:0];
      CFG_LIMIT:     reg_limit = data[LimitW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int unsigned floor_v, input int unsigned ceiling_v,
                          input int unsigned threshold_v, input int unsigned gain_v,
                          input int unsigned limit_v);
    write_reg(CFG_FLOOR, with_junk(floor_v, SB));
    write_reg(CFG_CEILING, with_junk(ceiling_v, SB));
    write_reg(CFG_THRESHOLD, with_junk(threshold_v, SB));
    write_reg(CFG_GAIN, with_junk(gain_v, GainW));
    write_reg(CFG_LIMIT, with_junk(limit_v, LimitW));
  endtask

  task automatic add_random_pairs(input int unsigned count);
    int unsigned lv, rv, kind;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      case (kind)
        4: begin
          lv = $urandom_range(0, reg_threshold);
          rv = $urandom_range(0, SampleMax);
        end
        5: begin
          lv = $urandom_range(0, SampleMax);
          rv = $urandom_range(0, reg_threshold);
        end
        6: begin
          // Small sums after a large kept difference push the quotient into saturation.
          lv = $urandom_range(0, 64);
          rv = $urandom_range(0, 64);
        end
        7: begin
          lv = $urandom_range(0, SampleMax);
          rv = lv;
        end
        8: begin
          lv = near_value(reg_threshold);
          rv = ($urandom_range(0, 1) != 0) ? near_value(reg_threshold)
                                           : $urandom_range(0, SampleMax);
        end
        9: begin
          lv = ($urandom_range(0, 1) != 0) ? SampleMax : 0;
          rv = ($urandom_range(0, 1) != 0) ? SampleMax : 0;
        end
        default: begin
          lv = $urandom_range(0, SampleMax);
          rv = $urandom_range(0, SampleMax);
        end
      endcase
      push_pair(lv, rv);
    end
  endtask

  // Waits for every request to drain, then for DrainCycles before any write.
  task automatic settle();
    while (pending_pairs.size() != 0 || in_valid_i || expected_errors.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : sample_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_errors.push_back(predict_position(left_sample_i, right_sample_i));
        in_gap = $urandom_range(0, in_gap_max);
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          in_valid_i <= 1'b1;
          left_sample_i <= pending_pairs[0].left;
          right_sample_i <= pending_pairs[0].right;
          void'(pending_pairs.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : error_monitor
    logic signed [OutW-1:0] want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_errors.size() == 0) begin
          $display("%0t: position error %0d with no request outstanding", $time,
                   position_error_o);
          mismatch_count++;
        end else begin
          want = expected_errors.pop_front();
          if (position_error_o !== want) begin
            $display("%0t: position_error expected %0d, got %0d", $time, want,
                     position_error_o);
            mismatch_count++;
          end
        end
        out_stall = $urandom_range(0, out_gap_max);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned floor_v, ceiling_v, threshold_v, gain_v, limit_v;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: weak and strong readings, sign rules, zero kept difference.
    push_pair(100, 50);
    push_pair(1000, 0);
    push_pair(0, 1200);
    push_pair(2000, 2000);
    push_pair(SampleMax, 0);
    push_pair(0, SampleMax);
    push_pair(SampleMax, SampleMax);
    push_pair(3000, 500);
    push_pair(600, 3900);
    push_pair(10, SampleMax);
    push_pair(0, 0);
    push_pair(300, 300);
    push_pair(299, 4000);
    push_pair(12'hAAA, 12'h555);
    push_pair(12'h555, 12'hAAA);
    push_pair(SampleMax, 300);
    push_pair(4049, 4051);
    push_pair(6, 4);
    settle();

    out_gap_max = 0;
    set_regs(0, SampleMax, 300, GainMax, LimitMax);
    add_random_pairs(70);
    settle();

    // Floor above the ceiling.
    in_gap_max = 5;
    out_gap_max = 5;
    set_regs(3000, 1000, 2000, 0, 0);
    for (int k = int'(CFG_LIMIT) + 1; k < (1 << CfgIdxW); k++)
      write_reg(CfgIdxW'(k), CfgDataW'($urandom));
    push_pair(2999, 3001);
    push_pair(3000, 1000);
    push_pair(999, 1001);
    push_pair(0, SampleMax);
    add_random_pairs(50);
    settle();

    set_regs(SampleMax, 0, SampleMax, 1, 1);
    add_random_pairs(40);
    settle();

    in_gap_max = 0;
    out_gap_max = 0;
    set_regs(0, SampleMax, 0, 512, 100);
    add_random_pairs(60);
    settle();

    repeat (8) begin
      floor_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SampleMax)
                                            : $urandom_range(0, 200);
      ceiling_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SampleMax)
                                              : $urandom_range(3800, SampleMax);
      threshold_v = $urandom_range(0, SampleMax);
      gain_v = $urandom_range(0, GainMax);
      limit_v = ($urandom_range(0, 2) == 0) ? LimitMax : $urandom_range(0, LimitMax);
      in_gap_max = ($urandom_range(0, 1) != 0) ? 5 : 0;
      out_gap_max = ($urandom_range(0, 1) != 0) ? 5 : 0;
      set_regs(floor_v, ceiling_v, threshold_v, gain_v, limit_v);
      add_random_pairs(60);
      settle();
    end

    if (expected_errors.size() != 0) begin
      $display("%0t: %0d position errors never arrived", $time, expected_errors.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
